### rtl/dhlt_pkg.sv
package dhlt_pkg;

    localparam int TAB_LEN = 30;
    localparam int TRIG_ITERATIONS_DEFAULT = 16;

    localparam int CORDIC_W = 34;
    localparam int Z_W = 33;
    localparam int TRIG_W = 18;
    localparam int PROD_W = 50;

    localparam logic [31:0] GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] TURN_HI = 32'd10430;
    localparam logic [31:0] TURN_LO = 32'd1625002897;
    localparam logic signed [TRIG_W-1:0] ONE_Q16 = 18'sd65536;

    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef enum logic [2:0] {
        REG_TWIST     = 3'd0,
        REG_LENGTH    = 3'd1,
        REG_ROTATION  = 3'd2,
        REG_OFFSET    = 3'd3,
        REG_PRISMATIC = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [Z_W-1:0]      z;
    } lane_t;

    typedef struct packed {
        logic [1:0]         q_theta;
        logic [1:0]         q_alpha;
        logic signed [31:0] link_length;
        logic signed [31:0] pos_z;
    } side_t;

    typedef struct packed {
        lane_t theta;
        lane_t alpha;
        side_t side;
    } cordic_t;

    // Packed with rot_00 in the lowest bits.
    typedef struct packed {
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_22;
        logic signed [31:0] rot_21;
        logic signed [31:0] pos_y;
        logic signed [31:0] rot_12;
        logic signed [31:0] rot_11;
        logic signed [31:0] rot_10;
        logic signed [31:0] pos_x;
        logic signed [31:0] rot_02;
        logic signed [31:0] rot_01;
        logic signed [31:0] rot_00;
    } out_t;

endpackage

### rtl/dhlt_phase.sv
module dhlt_phase
    import dhlt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] theta,
    input  logic signed [31:0] alpha,
    input  side_t              side_in,
    output logic               out_valid,
    input  logic               out_ready,
    output cordic_t            out_data
);

    typedef struct packed {
        logic        neg;
        logic [31:0] hi;
        logic [30:0] lo;
    } prod_t;

    typedef struct packed {
        prod_t theta;
        prod_t alpha;
        side_t side;
    } stage_t;

    function automatic prod_t phase_product(logic signed [31:0] ang);
        logic [31:0] mag;
        logic [45:0] hi;
        logic [62:0] lo;
        prod_t       r;
        mag = ang[31] ? 32'(-ang) : 32'(ang);
        hi = 46'(mag) * 46'(TURN_HI);
        lo = 63'(mag) * 63'(TURN_LO);
        r.neg = ang[31];
        r.hi = hi[31:0];
        r.lo = lo[62:32];
        return r;
    endfunction

    function automatic logic [31:0] phase_of(prod_t p);
        logic [31:0] ph;
        ph = p.hi + {1'b0, p.lo};
        if (p.neg)
        begin
            ph = 32'd0 - ph;
        end
        return ph;
    endfunction

    function automatic logic [1:0] quadrant(logic [31:0] ph);
        logic [31:0] t;
        t = ph + 32'h2000_0000;
        return t[31:30];
    endfunction

    function automatic lane_t lane_start(logic [31:0] ph);
        logic [31:0] rr;
        lane_t       l;
        rr = ph - {quadrant(ph), 30'd0};
        l.x = CORDIC_W'(GAIN_Q30);
        l.y = '0;
        l.z = {{(Z_W-32){rr[31]}}, rr};
        return l;
    endfunction

    logic    s1_valid_reg;
    logic    s1_valid_next;
    stage_t  s1_data_reg;
    stage_t  s1_data_next;
    logic    s1_ready;
    logic    s2_valid_reg;
    logic    s2_valid_next;
    cordic_t s2_data_reg;
    cordic_t s2_data_next;
    logic [31:0] ph_theta;
    logic [31:0] ph_alpha;

    assign s1_ready = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_ready;

    always_comb
    begin
        s1_valid_next = in_ready ? in_valid : 1'b1;
        s1_data_next.theta = phase_product(theta);
        s1_data_next.alpha = phase_product(alpha);
        s1_data_next.side = side_in;

        s2_valid_next = s1_ready ? s1_valid_reg : 1'b1;
        ph_theta = phase_of(s1_data_reg.theta);
        ph_alpha = phase_of(s1_data_reg.alpha);
        s2_data_next.theta = lane_start(ph_theta);
        s2_data_next.alpha = lane_start(ph_alpha);
        s2_data_next.side = s1_data_reg.side;
        s2_data_next.side.q_theta = quadrant(ph_theta);
        s2_data_next.side.q_alpha = quadrant(ph_alpha);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= s1_data_next;
        end
        if (s1_valid_reg && s1_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data = s2_data_reg;

endmodule

### rtl/dhlt_cordic_cell.sv
module dhlt_cordic_cell
    import dhlt_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_TAB[SHIFT]);

    function automatic lane_t rotate(lane_t l);
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        lane_t                      r;
        xs = l.x >>> SHIFT;
        ys = l.y >>> SHIFT;
        if (!l.z[Z_W-1])
        begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - ATAN_STEP;
        end
        else
        begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + ATAN_STEP;
        end
        return r;
    endfunction

    logic    valid_reg;
    logic    valid_next;
    cordic_t data_reg;
    cordic_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : 1'b1;
        data_next.theta = rotate(in_data.theta);
        data_next.alpha = rotate(in_data.alpha);
        data_next.side = in_data.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

### rtl/dhlt_product.sv
module dhlt_product
    import dhlt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output out_t    out_data
);

    typedef struct packed {
        logic signed [TRIG_W-1:0] ct;
        logic signed [TRIG_W-1:0] st;
        logic signed [TRIG_W-1:0] ca;
        logic signed [TRIG_W-1:0] sa;
        logic signed [31:0]       link_length;
        logic signed [31:0]       pos_z;
    } trig_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] st_ca;
        logic signed [PROD_W-1:0] st_sa;
        logic signed [PROD_W-1:0] a_ct;
        logic signed [PROD_W-1:0] ct_ca;
        logic signed [PROD_W-1:0] ct_sa;
        logic signed [PROD_W-1:0] a_st;
        logic signed [TRIG_W-1:0] ct;
        logic signed [TRIG_W-1:0] st;
        logic signed [TRIG_W-1:0] ca;
        logic signed [TRIG_W-1:0] sa;
        logic signed [31:0]       pos_z;
    } prods_t;

    function automatic logic signed [TRIG_W-1:0] to_q16(logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0]    t;
        logic signed [CORDIC_W-15:0]   r;
        logic signed [TRIG_W-1:0]      c;
        t = v + CORDIC_W'(8192);
        t = t >>> 14;
        r = t[CORDIC_W-15:0];
        if (r > (CORDIC_W-14)'(ONE_Q16))
        begin
            c = ONE_Q16;
        end
        else if (r < -(CORDIC_W-14)'(ONE_Q16))
        begin
            c = -ONE_Q16;
        end
        else
        begin
            c = r[TRIG_W-1:0];
        end
        return c;
    endfunction

    function automatic logic signed [31:0] round_sat(logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]    t;
        logic signed [PROD_W-17:0]   r;
        logic signed [31:0]          s;
        t = p + PROD_W'(32768);
        t = t >>> 16;
        r = t[PROD_W-17:0];
        if (r > (PROD_W-16)'(32'sh7FFF_FFFF))
        begin
            s = 32'sh7FFF_FFFF;
        end
        else if (r < (PROD_W-16)'(-33'sh8000_0000))
        begin
            s = 32'sh8000_0000;
        end
        else
        begin
            s = r[31:0];
        end
        return s;
    endfunction

    logic                     a_valid_reg;
    logic                     a_valid_next;
    trig_t                    a_data_reg;
    trig_t                    a_data_next;
    logic                     b_valid_reg;
    logic                     b_valid_next;
    prods_t                   b_data_reg;
    prods_t                   b_data_next;
    logic                     c_valid_reg;
    logic                     c_valid_next;
    out_t                     c_data_reg;
    out_t                     c_data_next;
    logic                     a_ready;
    logic                     b_ready;
    logic signed [TRIG_W-1:0] cx_t;
    logic signed [TRIG_W-1:0] sy_t;
    logic signed [TRIG_W-1:0] cx_a;
    logic signed [TRIG_W-1:0] sy_a;

    assign b_ready = !c_valid_reg || out_ready;
    assign a_ready = !b_valid_reg || b_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_comb
    begin
        a_valid_next = in_ready ? in_valid : 1'b1;
        cx_t = to_q16(in_data.theta.x);
        sy_t = to_q16(in_data.theta.y);
        cx_a = to_q16(in_data.alpha.x);
        sy_a = to_q16(in_data.alpha.y);
        case (in_data.side.q_theta)
            2'd0:
            begin
                a_data_next.ct = cx_t;
                a_data_next.st = sy_t;
            end
            2'd1:
            begin
                a_data_next.ct = -sy_t;
                a_data_next.st = cx_t;
            end
            2'd2:
            begin
                a_data_next.ct = -cx_t;
                a_data_next.st = -sy_t;
            end
            default:
            begin
                a_data_next.ct = sy_t;
                a_data_next.st = -cx_t;
            end
        endcase
        case (in_data.side.q_alpha)
            2'd0:
            begin
                a_data_next.ca = cx_a;
                a_data_next.sa = sy_a;
            end
            2'd1:
            begin
                a_data_next.ca = -sy_a;
                a_data_next.sa = cx_a;
            end
            2'd2:
            begin
                a_data_next.ca = -cx_a;
                a_data_next.sa = -sy_a;
            end
            default:
            begin
                a_data_next.ca = sy_a;
                a_data_next.sa = -cx_a;
            end
        endcase
        a_data_next.link_length = in_data.side.link_length;
        a_data_next.pos_z = in_data.side.pos_z;

        b_valid_next = a_ready ? a_valid_reg : 1'b1;
        b_data_next.st_ca = PROD_W'(a_data_reg.st) * PROD_W'(a_data_reg.ca);
        b_data_next.st_sa = PROD_W'(a_data_reg.st) * PROD_W'(a_data_reg.sa);
        b_data_next.a_ct = PROD_W'(a_data_reg.link_length) * PROD_W'(a_data_reg.ct);
        b_data_next.ct_ca = PROD_W'(a_data_reg.ct) * PROD_W'(a_data_reg.ca);
        b_data_next.ct_sa = PROD_W'(a_data_reg.ct) * PROD_W'(a_data_reg.sa);
        b_data_next.a_st = PROD_W'(a_data_reg.link_length) * PROD_W'(a_data_reg.st);
        b_data_next.ct = a_data_reg.ct;
        b_data_next.st = a_data_reg.st;
        b_data_next.ca = a_data_reg.ca;
        b_data_next.sa = a_data_reg.sa;
        b_data_next.pos_z = a_data_reg.pos_z;

        c_valid_next = b_ready ? b_valid_reg : 1'b1;
        c_data_next.rot_00 = 32'(b_data_reg.ct);
        c_data_next.rot_01 = -round_sat(b_data_reg.st_ca);
        c_data_next.rot_02 = round_sat(b_data_reg.st_sa);
        c_data_next.pos_x = round_sat(b_data_reg.a_ct);
        c_data_next.rot_10 = 32'(b_data_reg.st);
        c_data_next.rot_11 = round_sat(b_data_reg.ct_ca);
        c_data_next.rot_12 = -round_sat(b_data_reg.ct_sa);
        c_data_next.pos_y = round_sat(b_data_reg.a_st);
        c_data_next.rot_21 = 32'(b_data_reg.sa);
        c_data_next.rot_22 = 32'(b_data_reg.ca);
        c_data_next.pos_z = b_data_reg.pos_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_data_reg <= a_data_next;
        end
        if (a_valid_reg && a_ready)
        begin
            b_data_reg <= b_data_next;
        end
        if (b_valid_reg && b_ready)
        begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data = c_data_reg;

endmodule

### rtl/dh_link_transform.sv
// Each accepted beat passes the phase registers, CORDIC cells and product registers.
// Throughput is one beat per cycle while m_axis_tready is high; one CORDIC cell per iteration.
// Every stage holds its own valid bit, so bubbles close up and input is taken while
// a finished result waits at the output register.
// Reset clears all valid bits and sets every configuration register to zero.
module dh_link_transform
    import dhlt_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // joint_value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_00, rot_01, rot_02, pos_x, rot_10, rot_11, rot_12, pos_y, rot_21, rot_22, pos_z
    output logic [351:0] m_axis_tdata
);

    logic signed [31:0] twist_angle_reg;
    logic signed [31:0] link_length_reg;
    logic signed [31:0] fixed_rotation_reg;
    logic signed [31:0] fixed_offset_reg;
    logic               joint_is_prismatic_reg;

    logic signed [31:0] theta;
    side_t              side_in;
    cordic_t            chain_data  [TRIG_ITERATIONS+1];
    logic               chain_valid [TRIG_ITERATIONS+1];
    logic               chain_ready [TRIG_ITERATIONS+1];
    out_t               result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twist_angle_reg <= '0;
            link_length_reg <= '0;
            fixed_rotation_reg <= '0;
            fixed_offset_reg <= '0;
            joint_is_prismatic_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TWIST:     twist_angle_reg <= cfg_data;
                REG_LENGTH:    link_length_reg <= cfg_data;
                REG_ROTATION:  fixed_rotation_reg <= cfg_data;
                REG_OFFSET:    fixed_offset_reg <= cfg_data;
                REG_PRISMATIC: joint_is_prismatic_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        theta = joint_is_prismatic_reg ? fixed_rotation_reg : s_axis_tdata;
        side_in.q_theta = '0;
        side_in.q_alpha = '0;
        side_in.link_length = link_length_reg;
        side_in.pos_z = joint_is_prismatic_reg ? s_axis_tdata : fixed_offset_reg;
    end

    dhlt_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .theta     (theta),
        .alpha     (twist_angle_reg),
        .side_in   (side_in),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < TRIG_ITERATIONS; i++)
    begin : g_cell
        dhlt_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    dhlt_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[TRIG_ITERATIONS]),
        .in_ready  (chain_ready[TRIG_ITERATIONS]),
        .in_data   (chain_data[TRIG_ITERATIONS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    assign m_axis_tdata = result;

endmodule

### tb/sv/dh_link_transform_tb.sv
module dh_link_transform_tb
    import dhlt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRIG_ITERS = TRIG_ITERATIONS_DEFAULT;
    localparam int LATENCY = TRIG_ITERS + 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_PHASES = 10;
    localparam int BEATS_PER_PHASE = 110;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_FIELDS = 11;

    localparam logic [2:0] REG_SPARE = 3'(REG_PRISMATIC) + 3'd1;
    localparam logic [2:0] REG_SPARE_LAST = 3'd7;

    localparam logic [2:0] CHK_NONE = 3'b000;
    localparam logic [2:0] CHK_Z = 3'b100;
    localparam logic [2:0] CHK_ALL = 3'b111;

    localparam logic [31:0] HALF_PI = 32'h0001_921F;
    localparam logic [31:0] PI = 32'h0003_243F;
    localparam logic [31:0] MAX_Q16 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_Q16 = 32'h8000_0000;

    typedef enum logic {
        ROW_WRITE,
        ROW_BEAT
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  index;
        logic [31:0] value;
        logic [2:0]  typed;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } row_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } trig_pair_t;

    localparam int NUM_ROWS = 35;
    localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_BEAT, REG_TWIST, 32'h0000_0000, CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, 32'h0000_0001, CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, 32'hFFFF_FFFF, CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, MAX_Q16,       CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, MIN_Q16,       CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, HALF_PI,       CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, PI,            CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, 32'hFFFE_6DE1, CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, 32'h0004_B65F, CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, 32'h0006_487F, CHK_ALL, 32'h0, 32'h0, 32'h0},
        '{ROW_WRITE, REG_TWIST,  HALF_PI, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_WRITE, REG_LENGTH, MAX_Q16, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_WRITE, REG_OFFSET, MIN_Q16, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, 32'h0000_0000, CHK_Z, 32'h0, 32'h0, MIN_Q16},
        '{ROW_BEAT, REG_TWIST, PI,            CHK_Z, 32'h0, 32'h0, MIN_Q16},
        '{ROW_BEAT, REG_TWIST, 32'hC000_0000, CHK_Z, 32'h0, 32'h0, MIN_Q16},
        '{ROW_BEAT, REG_TWIST, 32'h3FFF_FFFF, CHK_Z, 32'h0, 32'h0, MIN_Q16},
        '{ROW_WRITE, REG_LENGTH, MIN_Q16, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_WRITE, REG_TWIST,  MIN_Q16, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, PI,      CHK_Z, 32'h0, 32'h0, MIN_Q16},
        '{ROW_BEAT, REG_TWIST, HALF_PI, CHK_Z, 32'h0, 32'h0, MIN_Q16},
        '{ROW_WRITE, REG_PRISMATIC, 32'hFFFF_FFFF, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_WRITE, REG_ROTATION,  MIN_Q16,       CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_WRITE, REG_TWIST,     MAX_Q16,       CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_WRITE, REG_SPARE,     32'hFFFF_FFFF, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, 32'h0000_0000, CHK_Z, 32'h0, 32'h0, 32'h0000_0000},
        '{ROW_BEAT, REG_TWIST, MAX_Q16,       CHK_Z, 32'h0, 32'h0, MAX_Q16},
        '{ROW_BEAT, REG_TWIST, MIN_Q16,       CHK_Z, 32'h0, 32'h0, MIN_Q16},
        '{ROW_BEAT, REG_TWIST, 32'h0000_0001, CHK_Z, 32'h0, 32'h0, 32'h0000_0001},
        '{ROW_BEAT, REG_TWIST, 32'hFFFF_FFFF, CHK_Z, 32'h0, 32'h0, 32'hFFFF_FFFF},
        '{ROW_WRITE, REG_ROTATION,  32'h0000_0000, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_WRITE, REG_PRISMATIC, 32'hFFFF_FFFE, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, PI, CHK_Z, 32'h0, 32'h0, MIN_Q16},
        '{ROW_WRITE, REG_OFFSET, MAX_Q16, CHK_NONE, 32'h0, 32'h0, 32'h0},
        '{ROW_BEAT, REG_TWIST, 32'h0001_0000, CHK_Z, 32'h0, 32'h0, MAX_Q16}
    };

    localparam string FIELD_NAME [NUM_FIELDS] = '{
        "rot_00", "rot_01", "rot_02", "pos_x", "rot_10", "rot_11",
        "rot_12", "pos_y", "rot_21", "rot_22", "pos_z"
    };

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // joint_value
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // rot_00, rot_01, rot_02, pos_x, rot_10, rot_11, rot_12, pos_y, rot_21, rot_22, pos_z
    logic [351:0] m_axis_tdata;

    logic signed [31:0] twist_reg;
    logic signed [31:0] length_reg;
    logic signed [31:0] rotation_reg;
    logic signed [31:0] offset_reg;
    logic               prismatic_reg;

    out_t pending_transforms [$];
    int   cycle_count;
    int   mismatches;
    int   beats_sent;
    int   transforms_checked;
    int   register_writes;
    bit   hold_request;

    dh_link_transform #(
        .TRIG_ITERATIONS(TRIG_ITERS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic longint clamp_unit(input longint v);
        if (v > longint'(ONE_Q16))
            return longint'(ONE_Q16);
        if (v < -longint'(ONE_Q16))
            return -longint'(ONE_Q16);
        return v;
    endfunction

    function automatic trig_pair_t sin_cos_q16(input logic signed [31:0] angle);
        longint unsigned mag;
        longint unsigned turns;
        logic [31:0]     phase;
        logic [31:0]     shifted;
        logic [1:0]      quad;
        logic [31:0]     resid;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint          c;
        longint          s;
        trig_pair_t      r;
        z = longint'(angle);
        mag = (z < 0) ? -z : z;
        turns = mag * TURN_HI + ((mag * TURN_LO) >> 32);
        phase = turns[31:0];
        if (angle < 0)
            phase = 32'd0 - phase;
        shifted = phase + 32'h2000_0000;
        quad = shifted[31:30];
        resid = phase - {quad, 30'd0};
        z = longint'($signed(resid));
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < TRIG_ITERS && i < TAB_LEN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        c = clamp_unit((x + 8192) >>> 14);
        s = clamp_unit((y + 8192) >>> 14);
        case (quad)
            2'd0:
            begin
                r.c = 32'(c);
                r.s = 32'(s);
            end
            2'd1:
            begin
                r.c = 32'(-s);
                r.s = 32'(c);
            end
            2'd2:
            begin
                r.c = 32'(-c);
                r.s = 32'(-s);
            end
            default:
            begin
                r.c = 32'(s);
                r.s = 32'(-c);
            end
        endcase
        return r;
    endfunction

    function automatic longint mul_q16(input longint a, input longint b);
        longint r;
        r = (a * b + 32768) >>> 16;
        if (r > 64'sd2147483647)
            return 64'sd2147483647;
        if (r < -64'sd2147483648)
            return -64'sd2147483648;
        return r;
    endfunction

    function automatic out_t predict_transform(input logic [31:0] joint);
        trig_pair_t theta_tr;
        trig_pair_t alpha_tr;
        longint     ct;
        longint     st;
        longint     ca;
        longint     sa;
        longint     len;
        out_t       e;
        theta_tr = sin_cos_q16(prismatic_reg ? rotation_reg : $signed(joint));
        alpha_tr = sin_cos_q16(twist_reg);
        ct = longint'(theta_tr.c);
        st = longint'(theta_tr.s);
        ca = longint'(alpha_tr.c);
        sa = longint'(alpha_tr.s);
        len = longint'(length_reg);
        e.rot_00 = theta_tr.c;
        e.rot_01 = 32'(-mul_q16(st, ca));
        e.rot_02 = 32'(mul_q16(st, sa));
        e.pos_x  = 32'(mul_q16(len, ct));
        e.rot_10 = theta_tr.s;
        e.rot_11 = 32'(mul_q16(ct, ca));
        e.rot_12 = 32'(-mul_q16(ct, sa));
        e.pos_y  = 32'(mul_q16(len, st));
        e.rot_21 = alpha_tr.s;
        e.rot_22 = alpha_tr.c;
        e.pos_z  = prismatic_reg ? joint : offset_reg;
        return e;
    endfunction

    function automatic logic [31:0] random_word();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return $urandom();
            4, 5, 6:
                return 32'(int'($urandom_range(0, 1647100)) - 823550);
            7:
            begin
                k = int'($urandom_range(0, 32)) - 16;
                return 32'(k * 51472 + int'($urandom_range(0, 6)) - 3);
            end
            8:
            begin
                case ($urandom_range(0, 4))
                    0: return MAX_Q16;
                    1: return MIN_Q16;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default:
                return 32'(int'($urandom_range(0, 32)) - 16);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 65)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 10)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_transforms.size() != 0)
            @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        register_writes++;
        case (idx)
            REG_TWIST:     twist_reg = value;
            REG_LENGTH:    length_reg = value;
            REG_ROTATION:  rotation_reg = value;
            REG_OFFSET:    offset_reg = value;
            REG_PRISMATIC: prismatic_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic drive_joint(input logic [31:0] joint, input int gap, input logic [2:0] typed,
                               input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz);
        out_t e;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = joint;
        do
            @(posedge clk);
        while (!s_axis_tready);
        e = predict_transform(joint);
        if (typed[0])
            e.pos_x = px;
        if (typed[1])
            e.pos_y = py;
        if (typed[2])
            e.pos_z = pz;
        pending_transforms.push_back(e);
        beats_sent++;
        if (beats_sent == 300 || beats_sent == 800)
            hold_request = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_transforms.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: random stalls, calm stretches, and a long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if ((cycle_count / 1500) % 4 != 0 && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        logic [351:0] want;
        logic [351:0] got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_transforms.size() == 0)
            begin
                report_mismatch($sformatf("result beat %h with no transform outstanding", got));
            end
            else
            begin
                want = pending_transforms.pop_front();
                transforms_checked++;
                for (int k = 0; k < NUM_FIELDS; k++)
                begin
                    if (got[k*32 +: 32] !== want[k*32 +: 32])
                        report_mismatch($sformatf("transform %0d %s expected %h got %h",
                                                  transforms_checked, FIELD_NAME[k],
                                                  want[k*32 +: 32], got[k*32 +: 32]));
                end
            end
        end
    end

    initial
    begin
        logic [31:0] pv;
        bit          steady;
        cycle_count = 0;
        mismatches = 0;
        beats_sent = 0;
        transforms_checked = 0;
        register_writes = 0;
        hold_request = 1'b0;
        twist_reg = '0;
        length_reg = '0;
        rotation_reg = '0;
        offset_reg = '0;
        prismatic_reg = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TWIST;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_WRITE)
                write_register(DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].value);
            else
                drive_joint(DIRECTED_ROWS[r].value, pick_gap(), DIRECTED_ROWS[r].typed,
                            DIRECTED_ROWS[r].pos_x, DIRECTED_ROWS[r].pos_y,
                            DIRECTED_ROWS[r].pos_z);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_register(REG_TWIST, random_word());
            write_register(REG_LENGTH, random_word());
            write_register(REG_ROTATION, random_word());
            write_register(REG_OFFSET, random_word());
            pv = $urandom();
            pv[0] = ($urandom_range(0, 2) == 0);
            write_register(REG_PRISMATIC, pv);
            if ($urandom_range(0, 2) == 0)
                write_register(3'($urandom_range(REG_SPARE_LAST, REG_SPARE)), $urandom());
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                drive_joint(random_word(), steady ? 0 : pick_gap(), CHK_NONE,
                            32'h0, 32'h0, 32'h0);
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_transforms.size() != 0)
            @(negedge clk);
        repeat (2 * LATENCY) @(negedge clk);

        $display("Sent %0d joint values across %0d register writes; checked %0d transforms.",
                 beats_sent, register_writes, transforms_checked);
        $display("Revolute and prismatic links, full-range angles and output hold-offs; "
                 , "%0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
